// File: hw/rtl/dnfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfs_pkg: shared types and constants of the drum slot finder
// Beat layouts, role codes and the search token that runs along the cells.
// ----------------------------------------------------------------------------
package dnfs_pkg;

   localparam int SLOT_W = 6;
   localparam int ROLE_W = 4;
   localparam int WANT_W = 3;
   localparam int DIGIT_W = 4;
   localparam int CSR_W = 7;
   localparam int CNT_W = 9;
   localparam int DIV_W = 15;
   localparam int MOD_K_W = 3;

   localparam logic [MOD_K_W-1:0] MOD_K_TOP = 3'd5;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [ROLE_W-1:0] ROLE_NONE = 4'd0;
   localparam logic [ROLE_W-1:0] ROLE_BLANK = 4'd1;
   localparam logic [ROLE_W-1:0] ROLE_AM = 4'd2;
   localparam logic [ROLE_W-1:0] ROLE_PM = 4'd3;
   localparam logic [ROLE_W-1:0] ROLE_WIFI = 4'd4;
   localparam logic [ROLE_W-1:0] ROLE_QUESTION = 4'd5;
   localparam logic [ROLE_W-1:0] ROLE_DIGIT0 = 4'd6;

   localparam logic [WANT_W-1:0] WANT_BLANK = 3'd0;
   localparam logic [WANT_W-1:0] WANT_DIGIT = 3'd1;
   localparam logic [WANT_W-1:0] WANT_AM = 3'd2;
   localparam logic [WANT_W-1:0] WANT_PM = 3'd3;
   localparam logic [WANT_W-1:0] WANT_WIFI = 3'd4;
   localparam logic [WANT_W-1:0] WANT_QUESTION = 3'd5;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [SLOT_W-1:0] CSR_RESET_SLOTS = 6'd0;
   localparam logic [CSR_W-1:0] SLOTS_RESET = 7'd64;

   typedef struct packed {
      logic                func;
      logic [SLOT_W-1:0]   slot_index;
      logic [ROLE_W-1:0]   slot_role;
      logic [WANT_W-1:0]   want_role;
      logic [DIGIT_W-1:0]  want_digit;
      logic                position_known;
      logic [SLOT_W-1:0]   current_position;
   } dnfs_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] target_slot;
      logic              fell_back;
      logic              no_blank;
   } dnfs_rsp_type;

   // hi: at or after the position, lo: before it
   typedef struct packed {
      logic              valid;
      logic              want_hi_hit;
      logic [SLOT_W-1:0] want_hi_slot;
      logic              want_lo_hit;
      logic [SLOT_W-1:0] want_lo_slot;
      logic              blank_hi_hit;
      logic [SLOT_W-1:0] blank_hi_slot;
      logic              blank_lo_hit;
      logic [SLOT_W-1:0] blank_lo_slot;
   } dnfs_token_type;

   function automatic logic [ROLE_W-1:0] code_for_want(
      input logic [WANT_W-1:0]  want,
      input logic [DIGIT_W-1:0] digit
   );
      logic [ROLE_W-1:0] code;
      case (want)
         WANT_BLANK:    code = ROLE_BLANK;
         WANT_DIGIT:    code = (digit <= DIGIT_MAX) ? ROLE_DIGIT0 + digit : ROLE_NONE;
         WANT_AM:       code = ROLE_AM;
         WANT_PM:       code = ROLE_PM;
         WANT_WIFI:     code = ROLE_WIFI;
         WANT_QUESTION: code = ROLE_QUESTION;
         default:       code = ROLE_NONE;
      endcase
      return code;
   endfunction

endpackage

// File: hw/rtl/dnfs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfs_cell: one drum slot
// Holds one role code and updates the passing search token, which it registers.
// ----------------------------------------------------------------------------
module dnfs_cell #(
   parameter int IDX = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [dnfs_pkg::SLOT_W-1:0]               wr_slot,
   input  logic [dnfs_pkg::ROLE_W-1:0]               wr_role,
   input  logic [dnfs_pkg::ROLE_W-1:0]               want_code,
   input  logic [dnfs_pkg::SLOT_W-1:0]               from_slot,
   input  logic [dnfs_pkg::CNT_W-1:0]                count,
   input  dnfs_pkg::dnfs_token_type                  tok_prev,
   output dnfs_pkg::dnfs_token_type                  tok_next
);
   import dnfs_pkg::*;

   localparam logic [CNT_W-1:0] SLOT_NUM = CNT_W'(IDX);
   localparam logic [SLOT_W-1:0] SLOT_TAG = SLOT_W'(IDX);

   logic [ROLE_W-1:0] role_ff, role_in;
   dnfs_token_type    tok_ff, tok_in;
   logic              in_range, ahead, hit_want, hit_blank;

   always_comb begin
      role_in = role_ff;
      if (wr_en && ({{(CNT_W-SLOT_W){1'b0}}, wr_slot} == SLOT_NUM)) begin
         role_in = wr_role;
      end
   end

   assign in_range = SLOT_NUM < count;
   assign ahead = SLOT_NUM >= {{(CNT_W-SLOT_W){1'b0}}, from_slot};
   assign hit_want = in_range && (want_code != ROLE_NONE) && (role_ff == want_code);
   assign hit_blank = in_range && (role_ff == ROLE_BLANK);

   always_comb begin
      tok_in = tok_prev;
      if (tok_prev.valid) begin
         if (hit_want && ahead && !tok_prev.want_hi_hit) begin
            tok_in.want_hi_hit = 1'b1;
            tok_in.want_hi_slot = SLOT_TAG;
         end
         if (hit_want && !ahead && !tok_prev.want_lo_hit) begin
            tok_in.want_lo_hit = 1'b1;
            tok_in.want_lo_slot = SLOT_TAG;
         end
         if (hit_blank && ahead && !tok_prev.blank_hi_hit) begin
            tok_in.blank_hi_hit = 1'b1;
            tok_in.blank_hi_slot = SLOT_TAG;
         end
         if (hit_blank && !ahead && !tok_prev.blank_lo_hit) begin
            tok_in.blank_lo_hit = 1'b1;
            tok_in.blank_lo_slot = SLOT_TAG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff <= ROLE_NONE;
         tok_ff.valid <= 1'b0;
      end else begin
         role_ff <= role_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.want_hi_hit <= tok_in.want_hi_hit;
      tok_ff.want_hi_slot <= tok_in.want_hi_slot;
      tok_ff.want_lo_hit <= tok_in.want_lo_hit;
      tok_ff.want_lo_slot <= tok_in.want_lo_slot;
      tok_ff.blank_hi_hit <= tok_in.blank_hi_hit;
      tok_ff.blank_hi_slot <= tok_in.blank_hi_slot;
      tok_ff.blank_lo_hit <= tok_in.blank_lo_hit;
      tok_ff.blank_lo_slot <= tok_in.blank_lo_slot;
   end

   assign tok_next = tok_ff;

endmodule

// File: hw/rtl/drum_nearest_forward_slot.sv
`timescale 1ns / 1ps
// A load beat is registered into its slot cell as it is taken. A query beat runs a
//   six-step modulo unit, then the search token walks the row of MAX_SLOTS slot
//   cells, and the result beat is registered; no new beat is taken until it is issued.
// Loads are taken one per cycle when idle.
// Reset: synchronous; all slots read as no role and the slot count returns to 64.
// ----------------------------------------------------------------------------
// drum_nearest_forward_slot: nearest forward slot finder of one split-flap drum
// Slot role table in a row of cells, searched by a token that walks the row.
// ----------------------------------------------------------------------------
module drum_nearest_forward_slot #(
   parameter int MAX_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dnfs_pkg::dnfs_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dnfs_pkg::dnfs_rsp_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [dnfs_pkg::CSR_W-1:0]    csr_write_data
);
   import dnfs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MOD  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } dnfs_state_type;

   dnfs_state_type       state_ff, state_in;
   logic [CSR_W-1:0]     slots_ff, slots_in;
   logic [MOD_K_W-1:0]   k_ff, k_in;
   logic [SLOT_W-1:0]    r_ff, r_in;
   logic [ROLE_W-1:0]    code_ff, code_in;
   logic                 launch_ff, launch_in;
   dnfs_rsp_type         fin_ff, fin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dnfs_rsp_type         rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     slots_ext, max_ext, count_eff;
   logic [DIV_W-1:0]     div_val;
   logic                 req_take, wr_en;
   dnfs_token_type       tok_chain [0:MAX_SLOTS];
   dnfs_token_type       tok_end;

   assign slots_ext = {{(CNT_W-CSR_W){1'b0}}, slots_ff};
   assign max_ext = CNT_W'(MAX_SLOTS);
   assign count_eff = (slots_ext > max_ext) ? max_ext : slots_ext;
   assign div_val = {{(DIV_W-CNT_W){1'b0}}, count_eff} << k_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take = req_valid && req_ready;
   assign wr_en = req_take && (req_data.func == FUNC_LOAD);

   assign tok_chain[0] = {launch_ff, {($bits(dnfs_token_type)-1){1'b0}}};

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      dnfs_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en),
         .wr_slot   (req_data.slot_index),
         .wr_role   (req_data.slot_role),
         .want_code (code_ff),
         .from_slot (r_ff),
         .count     (count_eff),
         .tok_prev  (tok_chain[i]),
         .tok_next  (tok_chain[i+1])
      );
   end

   assign tok_end = tok_chain[MAX_SLOTS];

   always_comb begin
      fin_in = fin_ff;
      if (tok_end.want_hi_hit || tok_end.want_lo_hit) begin
         fin_in.fell_back = 1'b0;
         fin_in.no_blank = 1'b0;
         fin_in.target_slot = tok_end.want_hi_hit ? tok_end.want_hi_slot
                                                  : tok_end.want_lo_slot;
      end else if (tok_end.blank_hi_hit || tok_end.blank_lo_hit) begin
         fin_in.fell_back = 1'b1;
         fin_in.no_blank = 1'b0;
         fin_in.target_slot = tok_end.blank_hi_hit ? tok_end.blank_hi_slot
                                                   : tok_end.blank_lo_slot;
      end else begin
         fin_in.fell_back = 1'b1;
         fin_in.no_blank = 1'b1;
         fin_in.target_slot = CSR_RESET_SLOTS;
      end
   end

   always_comb begin
      state_in = state_ff;
      slots_in = csr_write_enable ? csr_write_data : slots_ff;
      k_in = k_ff;
      r_in = r_ff;
      code_in = code_ff;
      launch_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.func == FUNC_QUERY)) begin
               r_in = req_data.position_known ? req_data.current_position : '0;
               code_in = code_for_want(req_data.want_role, req_data.want_digit);
               k_in = MOD_K_TOP;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if ({{(DIV_W-SLOT_W){1'b0}}, r_ff} >= div_val) begin
               r_in = r_ff - div_val[SLOT_W-1:0];
            end
            if (k_ff == '0) begin
               launch_in = 1'b1;
               state_in = ST_SCAN;
            end else begin
               k_in = k_ff - MOD_K_W'(1);
            end
         end
         ST_SCAN: begin
            if (tok_end.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = fin_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slots_ff <= SLOTS_RESET;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slots_ff <= slots_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      r_ff <= r_in;
      code_ff <= code_in;
      rsp_data_ff <= rsp_data_in;
      if (tok_end.valid) begin
         fin_ff <= fin_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: hw/rtl/dnfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnfs_checker: port-level checks of the drum slot finder
// Watches the beats at the top level and flags results that cannot occur.
// ----------------------------------------------------------------------------
module dnfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input dnfs_pkg::dnfs_req_type        req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input dnfs_pkg::dnfs_rsp_type        rsp_data
);
   import dnfs_pkg::*;

   a_no_blank_fell_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_blank |-> rsp_data.fell_back)
      else $error("no_blank without fell_back");

   a_no_blank_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_blank |-> (rsp_data.target_slot == '0))
      else $error("no_blank with non-zero target");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_QUERY) |=> !req_ready)
      else $error("query beat did not start a search");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind drum_nearest_forward_slot dnfs_checker u_dnfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the drum nearest forward slot finder
// Load and query beats go in through a bursty driver. A slot table and search
// held here predict every query answer at the beat where it is accepted. The
// monitor compares each answer, field by field, with the oldest one due,
// while the answer side stalls on a pattern of its own. The slot count is
// changed between phases, only once the finder is idle, across 0 to 127.
// ----------------------------------------------------------------------------
module tb_top;
   import dnfs_pkg::*;

   localparam int MAX_SLOTS = 64;
   localparam int SETTLE_CYCLES = MAX_SLOTS + 16;
   localparam int RUN_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dnfs_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dnfs_rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;

   logic [ROLE_W-1:0] flap_roles [MAX_SLOTS];
   logic [CSR_W-1:0] flap_count;

   dnfs_req_type beats_to_send[$];
   dnfs_rsp_type answers_due[$];

   int burst_left = 0;
   int gap_left = 0;
   int gap_pick;
   int stall_style = 0;
   int style_left = 0;
   int cycle_count = 0;
   int errors = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int answers_checked = 0;
   int fallbacks_seen = 0;
   int no_blank_seen = 0;
   int counts_tried = 0;

   drum_nearest_forward_slot #(
      .MAX_SLOTS(MAX_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // nearest slot holding code, forward from the position or lowest if unknown
   function automatic bit closest_holder(input logic [ROLE_W-1:0] code,
                                         input dnfs_req_type q, input int flaps,
                                         output int slot);
      int reach;
      int best_reach;
      bit hit;
      hit = 1'b0;
      slot = 0;
      best_reach = 0;
      if (code == ROLE_NONE) return 1'b0;
      for (int s = 0; s < flaps; s++) begin
         if (flap_roles[s] == code) begin
            reach = q.position_known ?
               (s + flaps - (int'(q.current_position) % flaps)) % flaps : s;
            if (!hit || reach < best_reach) begin
               hit = 1'b1;
               slot = s;
               best_reach = reach;
            end
         end
      end
      return hit;
   endfunction

   function automatic dnfs_rsp_type nearest_slot_answer(input dnfs_req_type q);
      dnfs_rsp_type a;
      logic [ROLE_W-1:0] code;
      int flaps;
      int slot;
      flaps = (flap_count > MAX_SLOTS) ? MAX_SLOTS : int'(flap_count);
      case (q.want_role)
         WANT_BLANK: begin
            code = ROLE_BLANK;
         end
         WANT_DIGIT: begin
            code = (q.want_digit > DIGIT_MAX) ? ROLE_NONE : ROLE_DIGIT0 + q.want_digit;
         end
         WANT_AM: begin
            code = ROLE_AM;
         end
         WANT_PM: begin
            code = ROLE_PM;
         end
         WANT_WIFI: begin
            code = ROLE_WIFI;
         end
         WANT_QUESTION: begin
            code = ROLE_QUESTION;
         end
         default: begin
            code = ROLE_NONE;
         end
      endcase
      a = '0;
      if (!closest_holder(code, q, flaps, slot)) begin
         a.fell_back = 1'b1;
         if (!closest_holder(ROLE_BLANK, q, flaps, slot)) begin
            a.no_blank = 1'b1;
            slot = 0;
         end
      end
      a.target_slot = slot[SLOT_W-1:0];
      return a;
   endfunction

   function automatic dnfs_req_type load_beat(input int idx, input logic [ROLE_W-1:0] role);
      dnfs_req_type b;
      logic [31:0] noise;
      noise = $urandom;
      b = noise[$bits(dnfs_req_type)-1:0];
      b.func = FUNC_LOAD;
      b.slot_index = idx[SLOT_W-1:0];
      b.slot_role = role;
      return b;
   endfunction

   function automatic dnfs_req_type query_beat(input logic [WANT_W-1:0] want,
                                               input logic [DIGIT_W-1:0] digit,
                                               input logic known, input int pos);
      dnfs_req_type b;
      logic [31:0] noise;
      noise = $urandom;
      b = noise[$bits(dnfs_req_type)-1:0];
      b.func = FUNC_QUERY;
      b.want_role = want;
      b.want_digit = digit;
      b.position_known = known;
      b.current_position = pos[SLOT_W-1:0];
      return b;
   endfunction

   task automatic queue_beat(input dnfs_req_type b);
      beats_to_send.insert(beats_to_send.size(), b);
   endtask

   task automatic report_mismatch(input string what, input int got, input int due);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, due);
      errors++;
   endtask

   task automatic wait_idle();
      while (beats_to_send.size() != 0 || req_valid || answers_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] slots, input int n_items);
      int span;
      int blank_pct;
      int r;
      logic [ROLE_W-1:0] role;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= slots;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      flap_count = slots;
      counts_tried++;
      @(negedge clock);
      span = (slots == 0) ? 1 : ((slots > MAX_SLOTS) ? MAX_SLOTS : int'(slots));
      blank_pct = $urandom_range(0, 30);
      if ($urandom_range(0, 1) == 1) begin
         for (int i = 0; i < MAX_SLOTS; i++) queue_beat(load_beat(i, ROLE_NONE));
      end
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 9) < 4) begin
            r = $urandom_range(0, 99);
            if (r < blank_pct) role = ROLE_BLANK;
            else if (r < blank_pct + 8) role = ROLE_NONE;
            else role = ROLE_W'($urandom_range(ROLE_AM, 15));
            queue_beat(load_beat(($urandom_range(0, 9) == 0) ?
               $urandom_range(0, MAX_SLOTS - 1) : $urandom_range(0, span - 1), role));
         end else begin
            queue_beat(query_beat(
               WANT_W'(($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) :
                  $urandom_range(WANT_BLANK, WANT_QUESTION)),
               DIGIT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) :
                  $urandom_range(0, 9)),
               $urandom_range(0, 3) != 0,
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_SLOTS - 1) :
                  $urandom_range(0, span - 1)));
         end
      end
      wait_idle();
   endtask

   // driver: present beats in bursts, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.func == FUNC_LOAD) begin
               flap_roles[req_data.slot_index] = req_data.slot_role;
               loads_sent++;
            end else begin
               answers_due.insert(answers_due.size(), nearest_slot_answer(req_data));
               queries_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= beats_to_send.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_pick = $urandom_range(0, 5);
                  if (gap_pick < 2) gap_left = 0;
                  else if (gap_pick == 5) gap_left = $urandom_range(20, 90);
                  else gap_left = $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each answer beat, stall on a changing pattern
   always @(posedge clock) begin
      dnfs_rsp_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("answer beat with nothing due", int'(rsp_data), -1);
            end else begin
               due = answers_due.pop_front();
               answers_checked++;
               if (due.fell_back) fallbacks_seen++;
               if (due.no_blank) no_blank_seen++;
               if (rsp_data.target_slot !== due.target_slot)
                  report_mismatch("target_slot", int'(rsp_data.target_slot),
                                  int'(due.target_slot));
               if (rsp_data.fell_back !== due.fell_back)
                  report_mismatch("fell_back", int'(rsp_data.fell_back),
                                  int'(due.fell_back));
               if (rsp_data.no_blank !== due.no_blank)
                  report_mismatch("no_blank", int'(rsp_data.no_blank),
                                  int'(due.no_blank));
            end
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(50, 400);
         end else begin
            style_left--;
         end
         case (stall_style)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
               rsp_ready <= (cycle_count[3:0] >= 4'd5);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("drum_nearest_forward_slot: mismatch");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_SLOTS; i++) flap_roles[i] = ROLE_NONE;
      flap_count = SLOTS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table: no role and no blank
      queue_beat(query_beat(WANT_BLANK, 4'd0, 1'b0, 0));
      queue_beat(query_beat(WANT_AM, 4'd0, 1'b1, 63));
      queue_beat(load_beat(63, ROLE_DIGIT0 + 4'd9));
      queue_beat(load_beat(0, ROLE_BLANK));
      queue_beat(load_beat(5, ROLE_AM));
      queue_beat(load_beat(40, ROLE_PM));
      queue_beat(load_beat(20, ROLE_WIFI));
      queue_beat(load_beat(33, ROLE_QUESTION));
      queue_beat(load_beat(10, ROLE_DIGIT0));
      queue_beat(load_beat(50, ROLE_BLANK));
      queue_beat(query_beat(WANT_DIGIT, 4'd9, 1'b1, 0));
      queue_beat(query_beat(WANT_DIGIT, 4'd0, 1'b0, 45));
      queue_beat(query_beat(WANT_AM, 4'd0, 1'b1, 6));
      queue_beat(query_beat(WANT_PM, 4'd0, 1'b1, 63));
      queue_beat(query_beat(WANT_WIFI, 4'd15, 1'b1, 21));
      queue_beat(query_beat(WANT_QUESTION, 4'd0, 1'b1, 33));
      queue_beat(query_beat(WANT_BLANK, 4'd0, 1'b1, 1));
      queue_beat(query_beat(WANT_BLANK, 4'd0, 1'b0, 51));
      // absent digit, undefined role, digit out of range: fall back to blank
      queue_beat(query_beat(WANT_DIGIT, 4'd5, 1'b1, 51));
      queue_beat(query_beat(3'd7, 4'd0, 1'b1, 49));
      queue_beat(query_beat(3'd6, 4'd0, 1'b0, 0));
      queue_beat(query_beat(WANT_DIGIT, 4'd12, 1'b1, 63));
      queue_beat(load_beat(0, ROLE_NONE));
      queue_beat(load_beat(50, ROLE_NONE));
      queue_beat(query_beat(WANT_AM, 4'd3, 1'b1, 40));
      wait_idle();

      run_phase(7'd2, 170);
      run_phase(7'd0, 60);
      run_phase(7'd127, 170);
      run_phase(7'd1, 120);
      run_phase(7'($urandom_range(3, 63)), 200);
      run_phase(7'd65, 150);
      run_phase(7'($urandom_range(3, 63)), 200);
      run_phase(7'd64, 200);
      run_phase(7'($urandom_range(3, 63)), 230);

      $display("%0d load and %0d query beats over %0d slot counts from 0 to 127",
               loads_sent, queries_sent, counts_tried);
      $display("%0d answers checked, %0d fell back to blank, %0d found no blank, %0d errors",
               answers_checked, fallbacks_seen, no_blank_seen, errors);
      if (errors == 0) begin
         $display("drum_nearest_forward_slot: match");
      end else begin
         $display("drum_nearest_forward_slot: mismatch");
      end
      $finish;
   end

endmodule
